// ===== sv/flash_page_map_builder_defines.svh =====
// assertion helpers shared by the map builder modules
`ifndef FLASH_PAGE_MAP_BUILDER_DEFINES_SVH
`define FLASH_PAGE_MAP_BUILDER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FPMB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define FPMB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/fpmb_pkg.sv =====
package fpmb_pkg;

  localparam int unsigned OPC_W    = 1;
  localparam int unsigned IN_IDX_W = 32;
  localparam int unsigned BLK_W    = 16;
  localparam int unsigned PG_W     = 6;
  localparam int unsigned ST_W     = 3;
  localparam int unsigned ADDR_W   = 36;
  localparam int unsigned LIMIT_W  = 18;
  localparam int unsigned CFG_W    = 36;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [OPC_W-1:0] OP_RECORD = 1'b0;
  localparam logic [OPC_W-1:0] OP_LOOKUP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE = 1'b1;

  localparam logic [LIMIT_W-1:0] MAP_LIMIT_RST = 18'd110848;
  localparam logic [ADDR_W-1:0]  DATA_BASE_RST = 36'd94896128;

  localparam logic [ST_W-1:0] ST_STORED = 3'd0;
  localparam logic [ST_W-1:0] ST_RANGE  = 3'd1;
  localparam logic [ST_W-1:0] ST_DUP    = 3'd2;
  localparam logic [ST_W-1:0] ST_HIT    = 3'd3;
  localparam logic [ST_W-1:0] ST_MISS   = 3'd4;

  localparam int unsigned PLANE_COUNT = 2;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic capture;
    logic eval;
    logic mul;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== sv/fpmb_ctrl.sv =====
`include "flash_page_map_builder_defines.svh"

module fpmb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fpmb_pkg::dp_sts_t sts,
  output fpmb_pkg::dp_cmd_t cmd
);
  import fpmb_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_MUL   = 5'b01000,
    S_SUM   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `FPMB_ASSERT_NEXT(a_accept_to_eval, in_valid && !in_stall, state_r == S_EVAL, "accepted transaction did not move to eval")
  `FPMB_ASSERT_NOW(a_capture_only_idle, cmd.capture, in_valid && !in_stall, "capture without accepted transaction")
  `FPMB_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_r), "controller state not one-hot")

endmodule

// ===== sv/fpmb_datapath.sv =====
`include "flash_page_map_builder_defines.svh"

module fpmb_datapath #(
  parameter int unsigned MAP_ENTRIES    = 131072,
  parameter int unsigned PAGES_IN_BLOCK = 64,
  parameter int unsigned PAGE_BYTES     = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fpmb_pkg::dp_cmd_t                cmd,
  output fpmb_pkg::dp_sts_t                sts,
  input  logic                             cfg_we,
  input  logic [fpmb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpmb_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic [fpmb_pkg::OPC_W-1:0]       in_opcode,
  input  logic [fpmb_pkg::IN_IDX_W-1:0]    in_logical_index,
  input  logic [fpmb_pkg::BLK_W-1:0]       in_phys_block,
  input  logic [fpmb_pkg::PG_W-1:0]        in_phys_page,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fpmb_pkg::ST_W-1:0]        out_status,
  output logic [fpmb_pkg::ADDR_W-1:0]      out_plane0_addr,
  output logic [fpmb_pkg::ADDR_W-1:0]      out_plane1_addr
);
  import fpmb_pkg::*;

  localparam int unsigned IDX_W       = $clog2(MAP_ENTRIES);
  localparam int unsigned BLOCK_BYTES = PAGES_IN_BLOCK * PAGE_BYTES;
  localparam int unsigned HALF_BYTES  = PAGE_BYTES / PLANE_COUNT;
  localparam int unsigned BB_W        = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned BOFF_W      = BLK_W + BB_W;
  localparam int unsigned HOFF_W      = $clog2(HALF_BYTES * (PAGES_IN_BLOCK + 64) + 1);

  typedef struct packed {
    logic             vld;
    logic [BLK_W-1:0] blk;
    logic [PG_W-1:0]  pg;
  } entry_t;

  entry_t mem [MAP_ENTRIES];

  logic [LIMIT_W-1:0] map_limit_r;
  logic [ADDR_W-1:0]  data_base_r;
  logic [IDX_W-1:0]   clr_cnt_r;

  logic [OPC_W-1:0]   op_r;
  logic [IDX_W-1:0]   idx_r;
  logic [BLK_W-1:0]   new_blk_r;
  logic [PG_W-1:0]    new_pg_r;
  logic               in_range_r;
  entry_t             rd_q;

  logic [ST_W-1:0]    status_r, status_nxt;
  logic               hit_r;
  logic [BLK_W-1:0]   blk_r;
  logic [PG_W-1:0]    pg_r;

  logic [BOFF_W-1:0]  boff_r;
  logic [HOFF_W-1:0]  hoff0_r;
  logic [HOFF_W-1:0]  hoff1_r;

  logic               out_valid_r;
  logic [ST_W-1:0]    out_status_r;
  logic [ADDR_W-1:0]  out_p0_r;
  logic [ADDR_W-1:0]  out_p1_r;

  logic               in_range;
  logic               wr_en;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;

  assign in_range = (in_logical_index < IN_IDX_W'(map_limit_r)) &&
                    (in_logical_index < IN_IDX_W'(MAP_ENTRIES));

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_limit_r <= MAP_LIMIT_RST;
      data_base_r <= DATA_BASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAP_LIMIT: map_limit_r <= cfg_wdata[LIMIT_W-1:0];
        CFG_DATA_BASE: data_base_r <= cfg_wdata[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + IDX_W'(1);
    end
  end

  assign sts.clr_last = (clr_cnt_r == IDX_W'(MAP_ENTRIES - 1));
  assign sts.out_free = !out_valid_r || !out_stall;

  // decision on the read entry
  always_comb begin
    wr_en = 1'b0;
    if (op_r == OP_RECORD) begin
      if (!in_range_r) begin
        status_nxt = ST_RANGE;
      end else if (rd_q.vld) begin
        status_nxt = ST_DUP;
      end else begin
        status_nxt = ST_STORED;
        wr_en      = 1'b1;
      end
    end else begin
      status_nxt = (in_range_r && rd_q.vld) ? ST_HIT : ST_MISS;
    end
  end

  assign mem_we    = cmd.clr_en || (cmd.eval && wr_en);
  assign mem_waddr = cmd.clr_en ? clr_cnt_r : idx_r;
  always_comb begin
    mem_wdata     = '0;
    if (!cmd.clr_en) begin
      mem_wdata.vld = 1'b1;
      mem_wdata.blk = new_blk_r;
      mem_wdata.pg  = new_pg_r;
    end
  end

  // map store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.capture) begin
      rd_q <= mem[in_logical_index[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_opcode;
      idx_r      <= in_logical_index[IDX_W-1:0];
      new_blk_r  <= in_phys_block;
      new_pg_r   <= in_phys_page;
      in_range_r <= in_range;
    end
    if (cmd.eval) begin
      status_r <= status_nxt;
      hit_r    <= (status_nxt == ST_HIT);
      blk_r    <= rd_q.blk;
      pg_r     <= rd_q.pg;
    end
    if (cmd.mul) begin
      boff_r  <= BOFF_W'(blk_r) * BOFF_W'(BLOCK_BYTES);
      hoff0_r <= HOFF_W'(pg_r) * HOFF_W'(HALF_BYTES);
      hoff1_r <= (HOFF_W'(pg_r) + HOFF_W'(PAGES_IN_BLOCK)) * HOFF_W'(HALF_BYTES);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= status_r;
      if (hit_r) begin
        out_p0_r <= data_base_r + ADDR_W'(boff_r) + ADDR_W'(hoff0_r);
        out_p1_r <= data_base_r + ADDR_W'(boff_r) + ADDR_W'(hoff1_r);
      end else begin
        out_p0_r <= '0;
        out_p1_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_plane0_addr = out_p0_r;
  assign out_plane1_addr = out_p1_r;

  `FPMB_ASSERT_NOW(a_store_in_range, cmd.eval && wr_en, in_range_r && (op_r == OP_RECORD), "map write for rejected record")
  `FPMB_ASSERT_NOW(a_no_overwrite, cmd.load_out, !(out_valid_r && out_stall), "result loaded over a held result")
  `FPMB_ASSERT_NOW(a_miss_zero, out_valid_r && (out_status_r != ST_HIT), (out_p0_r == '0) && (out_p1_r == '0), "nonzero address without hit")

endmodule

// ===== sv/flash_page_map_builder.sv =====
// one transaction at a time: a new input transaction is accepted only after the
//   previous result is loaded into the result register; the controller steps are
//   accept/read, evaluate/write, offset multiply, address add
// a stalled result register holds the sequence in its add step until taken
// reset: synchronous, active low; afterwards the map store is swept clear, one
//   entry per cycle for all MAP_ENTRIES entries (131072 by default), input stalled
module flash_page_map_builder #(
  parameter int unsigned MAP_ENTRIES    = 131072,
  parameter int unsigned PAGES_IN_BLOCK = 64,
  parameter int unsigned PAGE_BYTES     = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [fpmb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpmb_pkg::CFG_W-1:0]       cfg_wdata,
  // input transactions
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [fpmb_pkg::OPC_W-1:0]       in_opcode,
  input  logic [fpmb_pkg::IN_IDX_W-1:0]    in_logical_index,
  input  logic [fpmb_pkg::BLK_W-1:0]       in_phys_block,
  input  logic [fpmb_pkg::PG_W-1:0]        in_phys_page,
  // result transactions
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fpmb_pkg::ST_W-1:0]        out_status,
  output logic [fpmb_pkg::ADDR_W-1:0]      out_plane0_addr,
  output logic [fpmb_pkg::ADDR_W-1:0]      out_plane1_addr
);
  import fpmb_pkg::*;

  // command and status between controller and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller: clear sweep after reset, then one transaction at a time
  fpmb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: config registers, map store, offset multipliers, result register
  fpmb_datapath #(
    .MAP_ENTRIES    (MAP_ENTRIES),
    .PAGES_IN_BLOCK (PAGES_IN_BLOCK),
    .PAGE_BYTES     (PAGE_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_opcode        (in_opcode),
    .in_logical_index (in_logical_index),
    .in_phys_block    (in_phys_block),
    .in_phys_page     (in_phys_page),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_plane0_addr  (out_plane0_addr),
    .out_plane1_addr  (out_plane1_addr)
  );

endmodule

// ===== tb/flash_page_map_builder_tb.sv =====
module flash_page_map_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpmb_pkg::*;

  // block geometry, kept at the instance defaults
  localparam int unsigned MAP_SIZE      = 131072;
  localparam int unsigned PAGES_PER_BLK = 64;
  localparam int unsigned PAGE_SIZE     = 4096;

  localparam int unsigned SEG_COUNT     = 9;
  localparam int unsigned ITEMS_PER_SEG = 214;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 12;
  // the clear sweep after reset alone stalls input while all MAP_SIZE entries are cleared
  localparam int unsigned WATCHDOG_LIMIT = 500000;

  localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

  // one expected result transaction
  typedef struct {
    logic [ST_W-1:0]   status;
    logic [ADDR_W-1:0] plane0;
    logic [ADDR_W-1:0] plane1;
  } map_reply_t;

  // shadow copy of the page map plus the queue of replies still owed
  class page_map_tracker;
    bit                 mapped[MAP_SIZE];
    logic [BLK_W-1:0]   blk_of[MAP_SIZE];
    logic [PG_W-1:0]    pg_of[MAP_SIZE];
    logic [LIMIT_W-1:0] limit;
    logic [ADDR_W-1:0]  base;
    map_reply_t         owed[$];
    int unsigned        mismatches;

    function new();
      limit      = MAP_LIMIT_RST;
      base       = DATA_BASE_RST;
      mismatches = 0;
    endfunction

    function bit in_range(logic [IN_IDX_W-1:0] idx);
      return (idx < limit) && (idx < MAP_SIZE);
    endfunction

    function void note_request(logic [OPC_W-1:0] op, logic [IN_IDX_W-1:0] idx,
                               logic [BLK_W-1:0] blk, logic [PG_W-1:0] pg);
      map_reply_t        r;
      logic [16:0]       slot;
      logic [ADDR_W-1:0] blk_start;
      slot     = idx[16:0];
      r.plane0 = '0;
      r.plane1 = '0;
      if (op == OP_RECORD) begin
        if (!in_range(idx)) begin
          r.status = ST_RANGE;
        end else if (mapped[slot]) begin
          r.status = ST_DUP;
        end else begin
          mapped[slot] = 1'b1;
          blk_of[slot] = blk;
          pg_of[slot]  = pg;
          r.status     = ST_STORED;
        end
      end else begin
        if (!in_range(idx) || !mapped[slot]) begin
          r.status = ST_MISS;
        end else begin
          // two-plane interleave: plane 1 half pages sit one block-row later
          blk_start = base + ADDR_W'(blk_of[slot]) * PAGES_PER_BLK * PAGE_SIZE;
          r.plane0  = blk_start + ADDR_W'(pg_of[slot]) * (PAGE_SIZE / PLANE_COUNT);
          r.plane1  = blk_start
                      + (ADDR_W'(pg_of[slot]) + PAGES_PER_BLK) * (PAGE_SIZE / PLANE_COUNT);
          r.status  = ST_HIT;
        end
      end
      owed.push_back(r);
    endfunction

    function void check_reply(logic [ST_W-1:0] st, logic [ADDR_W-1:0] a0,
                              logic [ADDR_W-1:0] a1);
      map_reply_t r;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result status %0d plane0 %h plane1 %h",
                   $realtime, st, a0, a1);
        return;
      end
      r = owed.pop_front();
      if (st !== r.status || a0 !== r.plane0 || a1 !== r.plane1) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch status exp %0d got %0d, plane0 exp %h got %h, plane1 exp %h got %h",
                   $realtime, r.status, st, r.plane0, a0, r.plane1, a1);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MAP_LIMIT;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OPC_W-1:0]     in_opcode = OP_RECORD;
  logic [IN_IDX_W-1:0]  in_logical_index = '0;
  logic [BLK_W-1:0]     in_phys_block = '0;
  logic [PG_W-1:0]      in_phys_page = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ST_W-1:0]      out_status;
  logic [ADDR_W-1:0]    out_plane0_addr;
  logic [ADDR_W-1:0]    out_plane1_addr;

  // idle rates in percent, set per phase by the stimulus thread
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // long receiver hold request and its countdown
  logic        hold_start = 1'b0;
  int unsigned hold_left = 0;

  int unsigned quiet_cycles = 0;

  page_map_tracker tracker = new();

  // recently recorded indices, so lookups and duplicates hit real entries
  logic [IN_IDX_W-1:0] recent_idx[$];

  flash_page_map_builder #(
    .MAP_ENTRIES   (MAP_SIZE),
    .PAGES_IN_BLOCK(PAGES_PER_BLK),
    .PAGE_BYTES    (PAGE_SIZE)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_logical_index(in_logical_index),
    .in_phys_block   (in_phys_block),
    .in_phys_page    (in_phys_page),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_plane0_addr (out_plane0_addr),
    .out_plane1_addr (out_plane1_addr)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver back-pressure: random stalls, or a long hold when requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_start) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // both channel monitors; values read here are the ones before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0)
        tracker.note_request(in_opcode, in_logical_index, in_phys_block, in_phys_page);
      if (out_valid === 1'b1 && !out_stall)
        tracker.check_reply(out_status, out_plane0_addr, out_plane1_addr);
    end
  end

  // watchdog on cycles without any transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // offer one transaction; entered just after a rising edge, returns on the
  // edge where it was taken
  task automatic offer(input logic [OPC_W-1:0] op, input logic [IN_IDX_W-1:0] idx,
                       input logic [BLK_W-1:0] blk, input logic [PG_W-1:0] pg);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_logical_index <= idx;
    in_phys_block    <= blk;
    in_phys_page     <= pg;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (op == OP_RECORD && recent_idx.size() < 64) recent_idx.push_back(idx);
    else if (op == OP_RECORD) recent_idx[$urandom_range(63)] = idx;
  endtask

  // stop offering and wait for every owed result plus the pipeline depth
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both registers back to back while the block is idle
  task automatic program_map(input logic [LIMIT_W-1:0] limit,
                             input logic [ADDR_W-1:0] base);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAP_LIMIT;
    cfg_wdata <= CFG_W'(limit);
    @(posedge clk);
    cfg_index <= CFG_DATA_BASE;
    cfg_wdata <= CFG_W'(base);
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.limit = limit;
    tracker.base  = base;
  endtask

  // index mix: a local window, both range edges, and wide random values
  function automatic logic [IN_IDX_W-1:0] pick_index(input int unsigned win_lo);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return win_lo + $urandom_range(255);
    if (r < 70) return IN_IDX_W'(tracker.limit) + $urandom_range(3) - 2;
    if (r < 80) return MAP_SIZE + $urandom_range(3) - 2;
    if (r < 90) return $urandom_range(MAP_SIZE - 1);
    return $urandom;
  endfunction

  function automatic logic [BLK_W-1:0] pick_block();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 16'hFFFF;
    if (r < 15) return '0;
    return BLK_W'($urandom_range(16'hFFFF));
  endfunction

  initial begin
    logic [LIMIT_W-1:0]  seg_limit[SEG_COUNT];
    logic [ADDR_W-1:0]   seg_base[SEG_COUNT];
    int unsigned         cap;
    int unsigned         win_lo;
    int unsigned         sent;
    logic [IN_IDX_W-1:0] idx;
    logic [OPC_W-1:0]    op;

    // register settings per segment, extremes included
    seg_limit[0] = MAP_LIMIT_RST;               seg_base[0] = DATA_BASE_RST;
    seg_limit[1] = 18'd1;                       seg_base[1] = '0;
    seg_limit[2] = 18'd131072;                  seg_base[2] = ADDR_MAX;
    seg_limit[3] = {LIMIT_W{1'b1}};             seg_base[3] = ADDR_W'({$urandom, $urandom});
    seg_limit[4] = '0;                          seg_base[4] = ADDR_W'({$urandom, $urandom});
    seg_limit[5] = 18'd512;                     seg_base[5] = 36'hF_FFF0_0000;
    seg_limit[6] = LIMIT_W'($urandom_range(131072, 1));
    seg_base[6]  = ADDR_W'({$urandom, $urandom});
    seg_limit[7] = 18'd131072;                  seg_base[7] = '0;
    seg_limit[8] = MAP_LIMIT_RST;               seg_base[8] = DATA_BASE_RST;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // sender mostly busy, receiver mostly stalled
    tx_idle_pct = 13;
    rx_idle_pct = 83;

    // directed: miss, store, hit, duplicate keeps the first mapping
    offer(OP_LOOKUP, 32'd0, 16'h5555, 6'd21);
    offer(OP_RECORD, 32'd0, 16'h0000, 6'd0);
    offer(OP_LOOKUP, 32'd0, 16'h0000, 6'd0);
    offer(OP_RECORD, 32'd0, 16'h1234, 6'd5);
    offer(OP_LOOKUP, 32'd0, 16'h0000, 6'd0);
    // last legal index with the largest block and page
    offer(OP_RECORD, 32'd110847, 16'hFFFF, 6'd63);
    offer(OP_LOOKUP, 32'd110847, 16'h0000, 6'd0);
    // first index at the limit, at the store size, and the widest index
    offer(OP_RECORD, 32'd110848, 16'h0001, 6'd1);
    offer(OP_LOOKUP, 32'd110848, 16'h0000, 6'd0);
    offer(OP_RECORD, 32'd131072, 16'h0002, 6'd2);
    offer(OP_RECORD, 32'hFFFF_FFFF, 16'hAAAA, 6'd42);
    offer(OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 6'd63);
    offer(OP_RECORD, 32'd5, 16'hFFFF, 6'd0);
    offer(OP_LOOKUP, 32'd5, 16'h0000, 6'd0);
    // limit above the store size: the store still bounds the index
    program_map({LIMIT_W{1'b1}}, DATA_BASE_RST);
    offer(OP_RECORD, 32'd131071, 16'hABCD, 6'd63);
    offer(OP_RECORD, 32'd131072, 16'h0003, 6'd3);
    offer(OP_LOOKUP, 32'd131071, 16'h0000, 6'd0);
    offer(OP_LOOKUP, 32'd131072, 16'h0000, 6'd0);
    // zero limit rejects everything, mapped entries included
    program_map('0, ADDR_MAX);
    offer(OP_RECORD, 32'd3, 16'h0004, 6'd4);
    offer(OP_LOOKUP, 32'd0, 16'h0000, 6'd0);
    // top data base: address sums wrap
    program_map(18'd131072, ADDR_MAX);
    offer(OP_LOOKUP, 32'd110847, 16'h0000, 6'd0);
    offer(OP_LOOKUP, 32'd0, 16'h0000, 6'd0);

    for (int unsigned seg = 0; seg < SEG_COUNT; seg++) begin
      program_map(seg_limit[seg], seg_base[seg]);
      // three idle regimes, three segments each
      if (seg == 3) begin
        tx_idle_pct = 83;
        rx_idle_pct = 13;
      end else if (seg == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // long receiver hold while the sender keeps offering
        fork
          begin
            hold_start <= 1'b1;
            @(posedge clk);
            hold_start <= 1'b0;
          end
        join_none
      end
      cap = (seg_limit[seg] < MAP_SIZE) ? seg_limit[seg] : MAP_SIZE;
      win_lo = (cap > 256) ? $urandom_range(cap - 256) : 0;
      recent_idx.delete();
      sent = 0;
      while (sent < ITEMS_PER_SEG) begin
        if ($urandom_range(99) < 35) begin
          // record followed by a lookup of the same page
          idx = pick_index(win_lo);
          offer(OP_RECORD, idx, pick_block(), PG_W'($urandom_range(63)));
          offer(OP_LOOKUP, idx, BLK_W'($urandom_range(16'hFFFF)), PG_W'($urandom_range(63)));
          sent += 2;
        end else begin
          op = OPC_W'($urandom_range(1));
          if (recent_idx.size() != 0 && $urandom_range(99) < 50)
            idx = recent_idx[$urandom_range(recent_idx.size() - 1)];
          else
            idx = pick_index(win_lo);
          offer(op, idx, pick_block(), PG_W'($urandom_range(63)));
          sent++;
        end
      end
    end

    drain();
    if (tracker.mismatches == 0 && tracker.owed.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/fpmb_pkg.sv
sv/fpmb_ctrl.sv
sv/fpmb_datapath.sv
sv/flash_page_map_builder.sv
tb/flash_page_map_builder_tb.sv
